>>> sv/kcl_pkg.sv
// ----------------------------------------------------------------------------
// kcl_pkg: shared types, constants and tables of the keypad code lock
// Holds the register map, the phase encoding, the keymap and the
// seven-segment digit table.
// ----------------------------------------------------------------------------
package kcl_pkg;

    localparam int unsigned CODE_LENGTH = 4;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BEEP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UNLOCK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CODE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSED   = 3'd5;

    localparam logic [19:0] DEBOUNCE_RST = 20'd20000;
    localparam logic [19:0] BEEP_RST     = 20'd100;
    localparam logic [23:0] UNLOCK_RST   = 24'd5000;
    localparam logic [31:0] CODE_RST     = 32'h3433_3231;
    localparam logic [15:0] OPEN_RST     = 16'd2510;
    localparam logic [15:0] CLOSED_RST   = 16'd1000;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    typedef struct packed {
        logic [19:0] debounce_ticks;
        logic [19:0] beep_ticks;
        logic [23:0] unlock_ticks;
        logic [31:0] code_word;
        logic [15:0] open_pulse;
        logic [15:0] closed_pulse;
    } t_cfg;

    typedef enum logic [4:0] {
        PH_SCAN     = 5'b00001,
        PH_DEBOUNCE = 5'b00010,
        PH_RELEASE  = 5'b00100,
        PH_BEEP     = 5'b01000,
        PH_UNLOCK   = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [3:0]  row_drive;
        logic        key_valid;
        logic [7:0]  key_char;
        logic [6:0]  segment_pattern;
        logic        led_on;
        logic        buzz_on;
        logic [15:0] servo_pulse;
    } t_result;

    // Keymap, indexed by {row, column}
    function automatic logic [7:0] key_char_of(input logic [3:0] key);
        logic [7:0] ch;
        unique case (key)
            4'd0:  ch = "1";
            4'd1:  ch = "2";
            4'd2:  ch = "3";
            4'd3:  ch = "A";
            4'd4:  ch = "4";
            4'd5:  ch = "5";
            4'd6:  ch = "6";
            4'd7:  ch = "B";
            4'd8:  ch = "7";
            4'd9:  ch = "8";
            4'd10: ch = "9";
            4'd11: ch = "C";
            4'd12: ch = "*";
            4'd13: ch = "0";
            4'd14: ch = "#";
            4'd15: ch = "D";
            default: ch = "D";
        endcase
        return ch;
    endfunction

    // Segment lines for a digit value, bit 0 is segment a
    function automatic logic [6:0] digit_segments(input logic [3:0] digit);
        logic [6:0] seg;
        unique case (digit)
            4'd0: seg = 7'h3F;
            4'd1: seg = 7'h06;
            4'd2: seg = 7'h5B;
            4'd3: seg = 7'h4F;
            4'd4: seg = 7'h66;
            4'd5: seg = 7'h6D;
            4'd6: seg = 7'h7D;
            4'd7: seg = 7'h07;
            4'd8: seg = 7'h7F;
            4'd9: seg = 7'h6F;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

endpackage

>>> sv/kcl_cfg.sv
// ----------------------------------------------------------------------------
// kcl_cfg: configuration register file
// Six write-only registers loaded from the write port; unknown indexes
// are dropped and surplus data bits are cut off.
// ----------------------------------------------------------------------------
module kcl_cfg
    import kcl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks <= DEBOUNCE_RST;
            r_cfg.beep_ticks     <= BEEP_RST;
            r_cfg.unlock_ticks   <= UNLOCK_RST;
            r_cfg.code_word      <= CODE_RST;
            r_cfg.open_pulse     <= OPEN_RST;
            r_cfg.closed_pulse   <= CLOSED_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DEBOUNCE: r_cfg.debounce_ticks <= i_cfg_data[19:0];
                REG_BEEP:     r_cfg.beep_ticks     <= i_cfg_data[19:0];
                REG_UNLOCK:   r_cfg.unlock_ticks   <= i_cfg_data[23:0];
                REG_CODE:     r_cfg.code_word      <= i_cfg_data[31:0];
                REG_OPEN:     r_cfg.open_pulse     <= i_cfg_data[15:0];
                REG_CLOSED:   r_cfg.closed_pulse   <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/kcl_core.sv
// ----------------------------------------------------------------------------
// kcl_core: scanner and code lock state machine
// Holds the lock state and works out one tick per enabled cycle. The
// result reflects the row lines of the tick and the levels after it.
// ----------------------------------------------------------------------------
module kcl_core
    import kcl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [3:0] i_cols,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    t_phase      r_phase,    n_phase;
    logic [1:0]  r_scan_row, n_scan_row;
    logic [1:0]  r_held_col, n_held_col;
    logic [23:0] r_wait,     n_wait;
    logic [2:0]  r_code_pos, n_code_pos;
    logic        r_led,      n_led;
    logic [6:0]  r_pattern,  n_pattern;
    logic [15:0] r_pulse,    n_pulse;

    logic        count_done;
    logic [7:0]  held_char;
    logic [7:0]  want_char;
    logic [1:0]  pos;
    logic [1:0]  first_low;
    logic        key_valid;
    logic [7:0]  key_char;
    logic [3:0]  row_drive;

    assign count_done = (r_wait <= 24'd1);
    assign held_char  = key_char_of({r_scan_row, r_held_col});
    assign pos        = r_code_pos[1:0];
    assign want_char  = i_cfg.code_word[{pos, 3'b000} +: 8];

    // Lowest pressed column wins
    always_comb begin
        priority if (!i_cols[0]) first_low = 2'd0;
        else if (!i_cols[1])     first_low = 2'd1;
        else if (!i_cols[2])     first_low = 2'd2;
        else                     first_low = 2'd3;
    end

    always_comb begin
        n_phase    = r_phase;
        n_scan_row = r_scan_row;
        n_held_col = r_held_col;
        n_wait     = r_wait;
        n_code_pos = r_code_pos;
        n_led      = r_led;
        n_pattern  = r_pattern;
        n_pulse    = r_pulse;
        key_valid  = 1'b0;
        key_char   = 8'h00;

        if (r_phase == PH_SCAN || r_phase == PH_DEBOUNCE || r_phase == PH_RELEASE) begin
            row_drive = ~(4'b0001 << r_scan_row);
        end else begin
            row_drive = 4'hF;
        end

        unique case (r_phase)
            PH_DEBOUNCE: begin
                if (count_done) begin
                    n_phase = PH_RELEASE;
                end else begin
                    n_wait = r_wait - 24'd1;
                end
            end
            PH_RELEASE: begin
                if (i_cols[r_held_col]) begin
                    key_valid = 1'b1;
                    key_char  = held_char;
                    if (held_char >= CHAR_ZERO && held_char <= CHAR_NINE) begin
                        n_pattern = digit_segments(held_char[3:0]);
                    end
                    n_wait  = {4'b0000, i_cfg.beep_ticks};
                    n_phase = PH_BEEP;
                end
            end
            PH_BEEP: begin
                if (count_done) begin
                    n_phase    = PH_SCAN;
                    n_scan_row = 2'd0;
                    if (held_char != want_char) begin
                        n_led      = 1'b1;
                        n_code_pos = 3'd0;
                    end else begin
                        n_code_pos = {1'b0, pos} + 3'd1;
                        if (n_code_pos >= 3'(CODE_LENGTH)) begin
                            n_pulse = i_cfg.open_pulse;
                            n_led   = 1'b1;
                            n_wait  = i_cfg.unlock_ticks;
                            n_phase = PH_UNLOCK;
                        end
                    end
                end else begin
                    n_wait = r_wait - 24'd1;
                end
            end
            PH_UNLOCK: begin
                if (count_done) begin
                    n_pulse    = i_cfg.closed_pulse;
                    n_led      = 1'b0;
                    n_code_pos = 3'd0;
                    n_phase    = PH_SCAN;
                    n_scan_row = 2'd0;
                end else begin
                    n_wait = r_wait - 24'd1;
                end
            end
            default: begin
                n_phase = PH_SCAN;
                if (i_cols != 4'hF) begin
                    n_held_col = first_low;
                    n_wait     = {4'b0000, i_cfg.debounce_ticks};
                    n_phase    = PH_DEBOUNCE;
                end else begin
                    n_scan_row = r_scan_row + 2'd1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SCAN;
            r_scan_row <= 2'd0;
            r_held_col <= 2'd0;
            r_wait     <= 24'd0;
            r_code_pos <= 3'd0;
            r_led      <= 1'b0;
            r_pattern  <= 7'd0;
            r_pulse    <= 16'd0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_scan_row <= n_scan_row;
            r_held_col <= n_held_col;
            r_wait     <= n_wait;
            r_code_pos <= n_code_pos;
            r_led      <= n_led;
            r_pattern  <= n_pattern;
            r_pulse    <= n_pulse;
        end
    end

    always_comb begin
        o_result.row_drive       = row_drive;
        o_result.key_valid       = key_valid;
        o_result.key_char        = key_char;
        o_result.segment_pattern = n_pattern;
        o_result.led_on          = n_led;
        o_result.buzz_on         = (n_phase == PH_BEEP) || (n_phase == PH_UNLOCK);
        o_result.servo_pulse     = n_pulse;
    end

`ifndef SYNTH
    // The lock only stays open after a full code, with the LED lit.
    a_unlock_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_UNLOCK) |-> (r_led && r_code_pos >= 3'(CODE_LENGTH)))
        else $error("unlock phase without full code or LED");

    // A released key always starts the beep.
    a_release_beep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == PH_RELEASE && i_cols[r_held_col]) |=> (r_phase == PH_BEEP))
        else $error("released key did not start the beep");

    // State only moves when a tick is processed.
    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> ($stable(r_phase) && $stable(r_wait) && $stable(r_code_pos)))
        else $error("lock state changed without a tick");

    // Scanning rows only while the keypad is being read.
    a_rows_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BEEP || r_phase == PH_UNLOCK) |-> (o_result.row_drive == 4'hF))
        else $error("rows driven during beep or unlock");
`endif

endmodule

>>> sv/keypad_code_lock.sv
// ----------------------------------------------------------------------------
// keypad_code_lock: 4x4 keypad scanner with code lock
// Input register, lock state machine and result register in one pass.
//
//   Channel   Direction  Contents
//   s_axis    in         tick with column levels
//   m_axis    out        row lines, key, display, LED, buzzer, servo value
//   cfg       in         register writes, index 0..5
//
// One item is taken per cycle while results are taken; an item passes through
// the input register, the lock state machine and the result register in turn.
// A stalled result holds the result register and then the input register;
// the input side stalls only when both are full.
// Reset is synchronous and empties both registers.
// ----------------------------------------------------------------------------
module keypad_code_lock
    import kcl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [3:0] column_levels

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [39:0]           m_axis_tdata,   // [3:0] row_drive, [11:4] key_char,
                                                  // [18:12] segment_pattern, [19] led_on,
                                                  // [20] buzz_on, [36:21] servo_pulse
    output logic                  m_axis_tuser,   // [0] key_valid

    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg       cfg;
    t_result    result;

    logic       r_in_vld;
    logic [3:0] r_in_cols;
    logic       r_out_vld;
    t_result    r_out;

    logic       out_free;
    logic       step;

    assign out_free      = !r_out_vld || m_axis_tready;
    assign step          = r_in_vld && out_free;
    assign s_axis_tready = !r_in_vld || step;

    kcl_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    kcl_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_cols   (r_in_cols),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_cols <= s_axis_tdata[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out.key_valid;
    assign m_axis_tdata  = {3'b000, r_out.servo_pulse, r_out.buzz_on, r_out.led_on,
                            r_out.segment_pattern, r_out.key_char, r_out.row_drive};

endmodule
